// File: rtl/bhpq_pkg.sv
// Shared types, constants and codes for the binary heap priority queue.
package bhpq_pkg;

  localparam int CAPACITY_DEF      = 1024;
  localparam int KEY_WIDTH_DEF     = 32;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  localparam int FIELD_W     = 32;
  localparam int COUNT_OUT_W = 11;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Read address select.
  localparam logic [1:0] RD_LAST   = 2'd0;
  localparam logic [1:0] RD_PARENT = 2'd1;
  localparam logic [1:0] RD_LEFT   = 2'd2;
  localparam logic [1:0] RD_RIGHT  = 2'd3;

  // Write data select.
  localparam logic [1:0] WR_NONE   = 2'd0;
  localparam logic [1:0] WR_CUR    = 2'd1;
  localparam logic [1:0] WR_PARENT = 2'd2;
  localparam logic [1:0] WR_BEST   = 2'd3;

  typedef struct packed {
    logic               action;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   top_valid;
    logic [FIELD_W-1:0]     top_key;
    logic [FIELD_W-1:0]     top_payload;
    logic [COUNT_OUT_W-1:0] entry_total;
  } out_item_t;

  typedef struct packed {
    logic       ld_ins;
    logic       ld_rem;
    logic       ld_status;
    logic [1:0] status;
    logic       ld_cur;
    logic       ld_left;
    logic [1:0] rd_sel;
    logic [1:0] wr_sel;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic left_in;
    logic cur_wins;
    logic best_is_cur;
  } sts_t;

endpackage

// File: rtl/bhpq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bhpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/bhpq_ctrl.sv
// Sequencer for insert and remove operations of the heap.
module bhpq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_action,
  input  bhpq_pkg::sts_t sts,
  output bhpq_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);

  import bhpq_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LAST    = 3'd1;
  localparam logic [2:0] S_UP_CHK  = 3'd2;
  localparam logic [2:0] S_UP_CMP  = 3'd3;
  localparam logic [2:0] S_DN_CHK  = 3'd4;
  localparam logic [2:0] S_DN_LEFT = 3'd5;
  localparam logic [2:0] S_DN_CMP  = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.rd_sel    = RD_LAST;
    cmd.wr_sel    = WR_NONE;
    cmd.status    = ST_DONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.ld_status = 1'b1;
          if (in_action == ACT_INSERT) begin
            if (sts.full) begin
              cmd.status = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              cmd.ld_ins = 1'b1;
              state_nxt  = S_UP_CHK;
            end
          end else begin
            if (sts.empty) begin
              cmd.status = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              // Fetch the last item while the count drops.
              cmd.ld_rem = 1'b1;
              cmd.rd_sel = RD_LAST;
              state_nxt  = S_LAST;
            end
          end
        end
      end
      S_LAST: begin
        if (sts.empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd.ld_cur = 1'b1;
          state_nxt  = S_DN_CHK;
        end
      end
      S_UP_CHK: begin
        if (sts.pos_zero) begin
          cmd.wr_sel = WR_CUR;
          state_nxt  = S_DONE;
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.cur_wins) begin
          cmd.wr_sel = WR_PARENT;
          state_nxt  = S_UP_CHK;
        end else begin
          cmd.wr_sel = WR_CUR;
          state_nxt  = S_DONE;
        end
      end
      S_DN_CHK: begin
        if (!sts.left_in) begin
          cmd.wr_sel = WR_CUR;
          state_nxt  = S_DONE;
        end else begin
          cmd.rd_sel = RD_LEFT;
          state_nxt  = S_DN_LEFT;
        end
      end
      S_DN_LEFT: begin
        cmd.ld_left = 1'b1;
        cmd.rd_sel  = RD_RIGHT;
        state_nxt   = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts.best_is_cur) begin
          cmd.wr_sel = WR_CUR;
          state_nxt  = S_DONE;
        end else begin
          cmd.wr_sel = WR_BEST;
          state_nxt  = S_DN_CHK;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// File: rtl/bhpq_dp.sv
// Datapath of the heap: count, cursor, moving item, comparisons and heap store.
module bhpq_dp #(
  parameter int CAPACITY      = bhpq_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH     = bhpq_pkg::KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = bhpq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bhpq_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  bhpq_pkg::cmd_t      cmd,
  output bhpq_pkg::sts_t      sts,
  output bhpq_pkg::out_item_t out_item
);

  import bhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;
  localparam int EW = KEY_WIDTH + PAYLOAD_WIDTH;

  logic [CW-1:0]            count_r;
  logic [AW-1:0]            pos_r;
  logic [KEY_WIDTH-1:0]     cur_key_r;
  logic [PAYLOAD_WIDTH-1:0] cur_pay_r;
  logic [KEY_WIDTH-1:0]     left_key_r;
  logic [PAYLOAD_WIDTH-1:0] left_pay_r;
  logic                     l_better_r;
  logic                     order_mode_r;
  logic [1:0]               status_r;
  logic [KEY_WIDTH-1:0]     root_key_r;
  logic [PAYLOAD_WIDTH-1:0] root_pay_r;

  logic [63:0]              in_key_ext;
  logic [63:0]              in_pay_ext;
  logic [KEY_WIDTH-1:0]     key_in;
  logic [PAYLOAD_WIDTH-1:0] pay_in;
  logic [EW-1:0]            rdata;
  logic [KEY_WIDTH-1:0]     rd_key;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;
  logic [IW-1:0]            lc_idx;
  logic [IW-1:0]            rc_idx;
  logic [IW-1:0]            count_ext;
  logic [AW-1:0]            parent;
  logic [CW-1:0]            cnt_m1;
  logic                     rc_in;
  logic [KEY_WIDTH-1:0]     best_key;
  logic                     r_better;
  logic [AW-1:0]            raddr;
  logic                     we;
  logic [EW-1:0]            wdata;
  logic [63:0]              root_key_ext;
  logic [63:0]              root_pay_ext;
  logic [31:0]              count_w;

  // True when key a should sit above key b under the current order.
  function automatic logic better(input logic mode, input logic [KEY_WIDTH-1:0] a,
                                  input logic [KEY_WIDTH-1:0] b);
    better = mode ? (a > b) : (a < b);
  endfunction

  assign in_key_ext = 64'(in_item.key);
  assign in_pay_ext = 64'(in_item.payload);
  assign key_in     = in_key_ext[KEY_WIDTH-1:0];
  assign pay_in     = in_pay_ext[PAYLOAD_WIDTH-1:0];

  assign rd_key = rdata[EW-1:PAYLOAD_WIDTH];
  assign rd_pay = rdata[PAYLOAD_WIDTH-1:0];

  assign lc_idx    = {1'b0, pos_r, 1'b1};
  assign rc_idx    = lc_idx + IW'(1);
  assign count_ext = IW'(count_r);
  assign parent    = (pos_r - AW'(1)) >> 1;
  assign cnt_m1    = count_r - CW'(1);
  assign rc_in     = (rc_idx < count_ext);

  assign best_key = l_better_r ? left_key_r : cur_key_r;
  assign r_better = rc_in && better(order_mode_r, rd_key, best_key);

  always_comb begin
    case (cmd.rd_sel)
      RD_LAST:   raddr = cnt_m1[AW-1:0];
      RD_PARENT: raddr = parent;
      RD_LEFT:   raddr = lc_idx[AW-1:0];
      RD_RIGHT:  raddr = rc_idx[AW-1:0];
      default:   raddr = cnt_m1[AW-1:0];
    endcase
  end

  assign we = (cmd.wr_sel != WR_NONE);

  always_comb begin
    case (cmd.wr_sel)
      WR_CUR:    wdata = {cur_key_r, cur_pay_r};
      WR_PARENT: wdata = rdata;
      WR_BEST:   wdata = r_better ? rdata : {left_key_r, left_pay_r};
      default:   wdata = {cur_key_r, cur_pay_r};
    endcase
  end

  bhpq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (pos_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      order_mode_r <= 1'b0;
      status_r     <= ST_DONE;
    end else begin
      if (cfg_we) begin
        order_mode_r <= cfg_wdata;
      end
      if (cmd.ld_status) begin
        status_r <= cmd.status;
      end
      if (cmd.ld_ins) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.ld_rem) begin
        count_r <= cnt_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_ins) begin
      pos_r     <= count_r[AW-1:0];
      cur_key_r <= key_in;
      cur_pay_r <= pay_in;
    end else if (cmd.ld_rem) begin
      pos_r <= '0;
    end else if (cmd.wr_sel == WR_PARENT) begin
      pos_r <= parent;
    end else if (cmd.wr_sel == WR_BEST) begin
      pos_r <= r_better ? rc_idx[AW-1:0] : lc_idx[AW-1:0];
    end
    if (cmd.ld_cur) begin
      cur_key_r <= rd_key;
      cur_pay_r <= rd_pay;
    end
    if (cmd.ld_left) begin
      left_key_r <= rd_key;
      left_pay_r <= rd_pay;
      l_better_r <= better(order_mode_r, rd_key, cur_key_r);
    end
    // Shadow copy of the root so the top item needs no extra read.
    if (we && (pos_r == '0)) begin
      root_key_r <= wdata[EW-1:PAYLOAD_WIDTH];
      root_pay_r <= wdata[PAYLOAD_WIDTH-1:0];
    end
  end

  assign sts.full        = (count_r == CW'(CAPACITY));
  assign sts.empty       = (count_r == '0);
  assign sts.pos_zero    = (pos_r == '0);
  assign sts.left_in     = (lc_idx < count_ext);
  assign sts.cur_wins    = better(order_mode_r, cur_key_r, rd_key);
  assign sts.best_is_cur = !l_better_r && !r_better;

  assign root_key_ext = 64'(root_key_r);
  assign root_pay_ext = 64'(root_pay_r);
  assign count_w      = 32'(count_r);

  assign out_item.status      = status_r;
  assign out_item.top_valid   = !sts.empty;
  assign out_item.top_key     = sts.empty ? '0 : root_key_ext[FIELD_W-1:0];
  assign out_item.top_payload = sts.empty ? '0 : root_pay_ext[FIELD_W-1:0];
  assign out_item.entry_total = count_w[COUNT_OUT_W-1:0];

endmodule

// File: rtl/binary_heap_priority_queue.sv
// Top level of the binary heap priority queue: sequencer, datapath and heap store.
//
//   Channel   Handshake               Content
//   input     start / busy            in_item: action, key, payload
//   result    out_valid (1-cycle)     out_item: status, top_valid, top_key,
//                                               top_payload, entry_total
//   config    cfg_we                  cfg_wdata: order_mode (0 min on top)
//
// An item is accepted on a clock edge with start high and busy low. Busy stays
// high until the result has been shown; the result is presented for exactly one
// cycle with out_valid, and the next item can be accepted in the following cycle.
// An insert climbs level by level until it stops below the root or reaches it,
// a remove descends level by level from the root (it ends at once when it
// empties the heap), and a refused item goes straight to the result; the block
// returns to idle after each result. The pace of a sift is set by the single
// read port of the heap store: each level needs one read per compared item and
// a compare step.
// Reset (rst_n low, synchronous) empties the heap and selects min-first order;
// the store itself is not cleared, since only entries below the count are used.
// The receiver cannot stall results.
module binary_heap_priority_queue #(
  parameter int CAPACITY      = bhpq_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH     = bhpq_pkg::KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = bhpq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bhpq_pkg::in_item_t  in_item,
  output logic                out_valid,
  output bhpq_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  import bhpq_pkg::*;

  // Commands from the sequencer and status flags back from the datapath.
  cmd_t cmd;
  sts_t sts;

  // The sequencer walks the sift loop one level at a time: it issues the
  // store reads, waits for the registered read data and then lets the
  // datapath compare and write back the item that moves.
  bhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_item.action),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // The datapath holds the count, the cursor, the moving item and a shadow
  // copy of the root, so the result is ready as soon as the sift ends.
  bhpq_dp #(
    .CAPACITY      (CAPACITY),
    .KEY_WIDTH     (KEY_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule

// File: dv/heap_scoreboard_pkg.sv
// Scoreboard for the binary heap priority queue: shadow heap and result checking.
package heap_scoreboard_pkg;
  import bhpq_pkg::*;

  localparam int unsigned HEAP_DEPTH = CAPACITY_DEF;

  class heap_scoreboard;
    logic [FIELD_W-1:0] shadow_key [HEAP_DEPTH];
    logic [FIELD_W-1:0] shadow_payload [HEAP_DEPTH];
    int unsigned        held;
    bit                 max_first;
    out_item_t          awaited_tops[$];
    int                 mismatches;

    function new();
      held       = 0;
      max_first  = 1'b0;
      mismatches = 0;
    endfunction

    function void set_order(bit largest_on_top);
      max_first = largest_on_top;
    endfunction

    function int unsigned held_entries();
      return held;
    endfunction

    function int unsigned awaiting();
      return awaited_tops.size();
    endfunction

    // Strictly better only, so equal keys never move.
    function bit outranks(int unsigned a, int unsigned b);
      return max_first ? (shadow_key[a] > shadow_key[b]) : (shadow_key[a] < shadow_key[b]);
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic [FIELD_W-1:0] k;
      logic [FIELD_W-1:0] p;
      k = shadow_key[a];
      p = shadow_payload[a];
      shadow_key[a]     = shadow_key[b];
      shadow_payload[a] = shadow_payload[b];
      shadow_key[b]     = k;
      shadow_payload[b] = p;
    endfunction

    function void climb(int unsigned pos);
      int unsigned up;
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (!outranks(pos, up)) break;
        swap_slots(pos, up);
        pos = up;
      end
    endfunction

    function void descend();
      int unsigned pos;
      int unsigned lc;
      int unsigned rc;
      int unsigned best;
      pos = 0;
      forever begin
        lc   = 2 * pos + 1;
        rc   = 2 * pos + 2;
        best = pos;
        if (lc < held && outranks(lc, best)) best = lc;
        if (rc < held && outranks(rc, best)) best = rc;
        if (best == pos) break;
        swap_slots(best, pos);
        pos = best;
      end
    endfunction

    // Apply one accepted item to the shadow heap and queue the top it should report.
    function void note_accepted(in_item_t item);
      out_item_t top;
      top        = '0;
      top.status = ST_DONE;
      if (item.action == ACT_INSERT) begin
        if (held >= HEAP_DEPTH) begin
          top.status = ST_FULL;
        end else begin
          shadow_key[held]     = item.key;
          shadow_payload[held] = item.payload;
          held++;
          climb(held - 1);
        end
      end else begin
        if (held == 0) begin
          top.status = ST_EMPTY;
        end else begin
          held--;
          shadow_key[0]     = shadow_key[held];
          shadow_payload[0] = shadow_payload[held];
          descend();
        end
      end
      if (held > 0) begin
        top.top_valid   = 1'b1;
        top.top_key     = shadow_key[0];
        top.top_payload = shadow_payload[0];
      end
      top.entry_total = COUNT_OUT_W'(held);
      awaited_tops.push_back(top);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (awaited_tops.size() == 0) begin
        report_mismatch("result arrived with no item outstanding");
        return;
      end
      want = awaited_tops.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.top_valid !== want.top_valid)
        report_mismatch($sformatf("top_valid %0b, expected %0b", got.top_valid, want.top_valid));
      if (got.top_key !== want.top_key)
        report_mismatch($sformatf("top_key %h, expected %h", got.top_key, want.top_key));
      if (got.top_payload !== want.top_payload)
        report_mismatch($sformatf("top_payload %h, expected %h",
                                  got.top_payload, want.top_payload));
      if (got.entry_total !== want.entry_total)
        report_mismatch($sformatf("entry_total %0d, expected %0d",
                                  got.entry_total, want.entry_total));
    endtask
  endclass

endpackage

// File: dv/tb.sv
// Top-level testbench for the binary heap priority queue.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bhpq_pkg::*;
  import heap_scoreboard_pkg::*;

  // Cycles with neither an accepted item nor a result before the run is declared hung.
  // It allows for the slowest item plus the random idle cycles of the sender.
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_PCT      = 18;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_we;
  logic      cfg_wdata;

  heap_scoreboard sb;
  bit             steady;
  int             quiet;

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  binary_heap_priority_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Monitor and watchdog. Everything is sampled at the rising edge, where the
  // block's outputs still hold their pre-edge values. A result is checked
  // before a new item is noted, in case both land on the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_item);
      if (start && !busy) sb.note_accepted(in_item);
    end
    if (!rst_n || out_valid || (start && !busy)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [FIELD_W-1:0] random_key();
    // Mix of extremes, a narrow range that forces equal keys, single set bits
    // and full-width random values.
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4: return FIELD_W'($urandom_range(15));
      5: return FIELD_W'(1) << $urandom_range(FIELD_W - 1);
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_item(int insert_pct);
    in_item_t item;
    item.action  = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
    item.key     = random_key();
    item.payload = ($urandom_range(15) == 0) ? '1 : FIELD_W'($urandom);
    return item;
  endfunction

  function automatic in_item_t make_item(logic act, logic [FIELD_W-1:0] key,
                                         logic [FIELD_W-1:0] payload);
    in_item_t item;
    item.action  = act;
    item.key     = key;
    item.payload = payload;
    return item;
  endfunction

  // Present one item, entered and left at a falling edge, and hold it until it
  // is accepted. In every cycle the sender may drop start at random, except in
  // the steady stretch, so the block also sees items that arrive late.
  task automatic send_item(in_item_t item);
    bit taken;
    taken   = 1'b0;
    in_item <= item;
    while (!taken) begin
      start <= steady || ($urandom_range(99) >= IDLE_PCT);
      @(posedge clk);
      taken = start && !busy;
      @(negedge clk);
    end
  endtask

  // Hold the sender off until every outstanding result has arrived.
  task automatic drain();
    start <= 1'b0;
    while (sb.awaiting() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // The order mode register is only written while the block is idle.
  task automatic write_order(bit largest_on_top);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= largest_on_top;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_order(largest_on_top);
  endtask

  initial begin
    int fill_count;
    sb        = new();
    steady    = 1'b0;
    quiet     = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, smallest key on top. Starts with a remove on an empty
    // heap, then extremes of key and payload and a run of equal keys whose
    // payloads show whether ties were left in place.
    write_order(1'b0);
    send_item(make_item(ACT_REMOVE, '1, '1));
    send_item(make_item(ACT_INSERT, 32'd5, 32'h0000_000a));
    send_item(make_item(ACT_INSERT, 32'd5, 32'h0000_000b));
    send_item(make_item(ACT_INSERT, '1, '0));
    send_item(make_item(ACT_INSERT, '0, '1));
    send_item(make_item(ACT_INSERT, 32'd5, 32'h0000_000c));
    send_item(make_item(ACT_INSERT, 32'd3, 32'h5555_5555));
    repeat (7) send_item(make_item(ACT_REMOVE, 32'haaaa_aaaa, 32'h5555_5555));

    // Largest key on top, again with a tie.
    write_order(1'b1);
    send_item(make_item(ACT_INSERT, 32'd7, 32'h0000_0001));
    send_item(make_item(ACT_INSERT, 32'd9, 32'h0000_0002));
    send_item(make_item(ACT_INSERT, 32'd9, 32'h0000_0003));
    send_item(make_item(ACT_INSERT, 32'd2, 32'h0000_0004));
    send_item(make_item(ACT_INSERT, '1, 32'h0000_0005));
    repeat (3) send_item(make_item(ACT_REMOVE, '0, '0));

    // Small heap with frequent removes, so empty-heap refusals recur.
    repeat (40) send_item(random_item(55));

    // Switch back to min-first with entries still held; the old max-first
    // layout stays and later sifts compare under the new order. Then fill
    // the store to capacity with mostly inserts, with one long stretch in
    // which the sender never idles.
    write_order(1'b0);
    fill_count = 0;
    while (sb.held_entries() < HEAP_DEPTH) begin
      steady = (fill_count >= 200 && fill_count < 450);
      send_item(random_item(98));
      fill_count++;
    end
    steady = 1'b0;
    // Inserts into the full store are refused; then work around the boundary.
    repeat (4) send_item(random_item(100));
    repeat (8) send_item(random_item(50));

    // Flip the order again with the store at or near capacity and run a balanced mix.
    write_order(1'b1);
    repeat (40) send_item(random_item(50));

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: binary_heap_priority_queue.f
rtl/bhpq_pkg.sv
rtl/bhpq_ram.sv
rtl/bhpq_ctrl.sv
rtl/bhpq_dp.sv
rtl/binary_heap_priority_queue.sv
dv/heap_scoreboard_pkg.sv
dv/tb.sv
